// ===== rtl/skms_pkg.sv =====
// ----------------------------------------------------------------------------
// skms_pkg: shared types and constants for the SOS Kawasaki step
// Field widths, register resets and indexes, the exp(-2^-k) constant table
// and the request/status structs between the sequencer and the exp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skms_pkg;

  // ring size default
  localparam int SITES_DEFAULT = 256;

  // field widths
  localparam int SITE_W   = 8;
  localparam int DRAW_W   = 32;
  localparam int HEIGHT_W = 6;
  localparam int ENERGY_W = 14;
  localparam int DELTA_W  = 4;
  localparam int BOND_W   = 20;
  localparam int DRIVE_W  = 22;
  localparam int FIELD_W  = 22;
  localparam int LIMIT_W  = 5;
  localparam int CFG_W    = 22;
  localparam int CFG_IDX_W = 2;

  // exponent: signed Q16, integer part to 5 bits is all the exp unit takes
  localparam int EXPO_W = 26;
  localparam int FRAC_W = 16;
  localparam int INT_W  = 5;
  localparam int PROB_W = 33;   // running probability, holds 1.0 in Q32

  // register reset values
  localparam logic [BOND_W-1:0]         BOND_RESET  = 20'd28881;
  localparam logic signed [DRIVE_W-1:0] DRIVE_RESET = 22'sd115522;
  localparam logic signed [FIELD_W-1:0] FIELD_RESET = 22'sd2888;
  localparam logic [LIMIT_W-1:0]        LIMIT_RESET = 5'd25;

  // exp(-1) in Q32
  localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOND_WEIGHT  = 2'd0,
    REG_DRIVE_WEIGHT = 2'd1,
    REG_FIELD_WEIGHT = 2'd2,
    REG_HEIGHT_LIMIT = 2'd3
  } cfg_reg_t;

  typedef logic [31:0] exp_table_t [FRAC_W];

  // integer square root of a 64-bit value, bit-pair method
  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = v;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  // entry k holds exp(-2^-(k+1)) in Q32, each the floored root of the last
  function automatic exp_table_t exp_table();
    exp_table_t  t;
    logic [31:0] c;
    c = EXP_M1_Q32;
    for (int k = 0; k < FRAC_W; k++) begin
      c    = isqrt64({c, 32'd0});
      t[k] = c;
    end
    return t;
  endfunction

  localparam exp_table_t EXP_FRAC_Q32 = exp_table();

  // sequencer to exp unit
  typedef struct packed {
    logic              go;
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac;
  } exp_req_t;

  // exp unit to sequencer
  typedef struct packed {
    logic done;
    logic accept;
  } exp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/skms_ram.sv =====
// ----------------------------------------------------------------------------
// skms_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/skms_exp.sv =====
// ----------------------------------------------------------------------------
// skms_exp: iterative Metropolis test against exp(-E)
// One shared 33x32 multiplier scales a running probability by exp(-2^-k)
// for each set fraction bit, then by exp(-1) once per integer unit.
// Stops early once the draw is no longer below the running probability.
// ----------------------------------------------------------------------------
`default_nettype none

module skms_exp
  import skms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire exp_req_t          req,
  input  wire logic [DRAW_W-1:0] draw,
  output exp_stat_t              stat
);

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_FRAC,
    EX_INT,
    EX_DONE
  } ex_state_t;

  localparam logic [3:0]        K_LAST  = 4'(FRAC_W - 1);
  localparam logic [PROB_W-1:0] P_ONE   = PROB_W'(64'h1_0000_0000);
  localparam logic [INT_W-1:0]  N_LAST  = INT_W'(1);

  ex_state_t          state_r;
  logic [3:0]         k_r;
  logic [INT_W-1:0]   n_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [DRAW_W-1:0]  draw_r;
  logic [PROB_W-1:0]  p_r;
  exp_stat_t          stat_r;

  logic [31:0]        mul_b;
  logic [64:0]        prod;
  logic [PROB_W-1:0]  p_nxt;
  logic               live;

  // shared multiplier: fraction constant or exp(-1)
  always_comb begin
    mul_b = (state_r == EX_FRAC) ? EXP_FRAC_Q32[k_r] : EXP_M1_Q32;
    prod  = {32'd0, p_r} * {33'd0, mul_b};
    p_nxt = prod[64:32];
    live  = {1'b0, draw_r} < p_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EX_IDLE;
      stat_r  <= '0;
    end else begin
      stat_r <= '0;
      unique case (state_r)
        EX_IDLE: begin
          if (req.go) begin
            p_r     <= P_ONE;
            k_r     <= '0;
            n_r     <= req.int_part;
            frac_r  <= req.frac;
            draw_r  <= draw;
            state_r <= EX_FRAC;
          end
        end
        EX_FRAC: begin
          if (!live) begin
            state_r <= EX_DONE;
          end else begin
            // bit weight 2^-(k+1) sits at frac position FRAC_W-1-k
            if (frac_r[~k_r]) begin
              p_r <= p_nxt;
            end
            k_r <= k_r + 4'd1;
            if (k_r == K_LAST) begin
              state_r <= (n_r == '0) ? EX_DONE : EX_INT;
            end
          end
        end
        EX_INT: begin
          if (!live) begin
            state_r <= EX_DONE;
          end else begin
            p_r <= p_nxt;
            n_r <= n_r - N_LAST;
            if (n_r == N_LAST) begin
              state_r <= EX_DONE;
            end
          end
        end
        EX_DONE: begin
          stat_r.done   <= 1'b1;
          stat_r.accept <= live;
          state_r       <= EX_IDLE;
        end
        default: state_r <= EX_IDLE;
      endcase
    end
  end

  assign stat = stat_r;

endmodule

`default_nettype wire

// ===== rtl/sos_kawasaki_metropolis_step.sv =====
// ----------------------------------------------------------------------------
// sos_kawasaki_metropolis_step: Kawasaki-Metropolis move on an SOS ring
// Keeps the column heights and running bond energy; takes one proposed move
// per item and returns one result item.
// ----------------------------------------------------------------------------
// After reset the block zeroes every address of the height RAM with busy
// high; configuration writes are taken during that pass. An item is taken
// when start is high and busy is low; busy stays high until the cycle in
// which its result is strobed on out_valid for a single cycle, which the
// receiver must take as it comes. An item that needs no exponential passes
// four neighbour reads through the single RAM read port, the evaluate and
// weigh states and, if accepted, the two height writes. Otherwise it also
// waits on the shared multiplier in the exp unit, which steps through the
// fraction bits and then once per integer unit of the exponent (at most
// 31), ending early when the draw already fails part way.
// ----------------------------------------------------------------------------
`default_nettype none

module sos_kawasaki_metropolis_step
  import skms_pkg::*;
#(
  parameter int SITES = SITES_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // item in
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [SITE_W-1:0]          in_site,
  input  wire logic                       in_direction,
  input  wire logic [DRAW_W-1:0]          in_uniform_draw,
  // result out
  output logic                            out_valid,
  output logic                            out_accepted,
  output logic signed [DELTA_W-1:0]       out_energy_change,
  output logic [ENERGY_W-1:0]             out_bond_energy,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data
);

  localparam int IW = $clog2(SITES);
  localparam logic [IW-1:0]        ADDR_LAST = IW'(SITES - 1);
  localparam logic signed [IW+1:0] SITES_S   = (IW+2)'(SITES);

  // neighbour read slots, in read order
  localparam logic [2:0] SLOT_NEAR = 3'd0;   // receiving column's outer neighbour
  localparam logic [2:0] SLOT_SITE = 3'd1;   // receiving column
  localparam logic [2:0] SLOT_PAIR = 3'd2;   // giving column
  localparam logic [2:0] SLOT_FAR  = 3'd3;   // beyond the giving column
  localparam logic [2:0] RD_END    = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WEIGH,
    ST_EXP,
    ST_WR0,
    ST_WR1
  } state_t;

  typedef logic signed [HEIGHT_W-1:0] height_t;

  // configuration registers
  logic [BOND_W-1:0]         bond_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic signed [FIELD_W-1:0] field_r;
  logic [LIMIT_W-1:0]        limit_r;

  // sequencer state and item registers
  state_t                    state_r;
  logic [IW-1:0]             clr_cnt_r;
  logic [2:0]                rd_cnt_r;
  logic [IW-1:0]             x_r;
  logic                      dir_r;
  logic [DRAW_W-1:0]         draw_r;
  height_t                   h_r [4];
  logic signed [DELTA_W-1:0] db_r;
  logic signed [1:0]         m_r;
  logic                      lim_hit_r;
  logic [ENERGY_W-1:0]       energy_r;

  logic                      out_valid_r;
  logic                      out_accepted_r;
  logic signed [DELTA_W-1:0] out_delta_r;
  logic [ENERGY_W-1:0]       out_energy_r;

  // combinational
  logic [IW-1:0]             site_idx;
  logic signed [2:0]         step_s;
  logic signed [2:0]         offset;
  logic signed [IW+1:0]      ring_sum;
  logic signed [IW+1:0]      ring_adj;
  logic [IW-1:0]             ring_addr;
  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic [HEIGHT_W-1:0]       ram_wdata;
  logic [HEIGHT_W-1:0]       ram_rdata;
  logic [1:0]                slot_prev;
  logic signed [DELTA_W-1:0] db_nxt;
  logic signed [1:0]         m_nxt;
  logic                      lim_nxt;
  logic signed [EXPO_W-1:0]  expo;
  logic                      expo_pos;
  logic                      expo_big;
  logic [ENERGY_W-1:0]       energy_nxt;
  exp_req_t                  exp_req;
  exp_stat_t                 exp_stat;

  // --------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bond_r  <= BOND_RESET;
      drive_r <= DRIVE_RESET;
      field_r <= FIELD_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOND_WEIGHT:  bond_r  <= cfg_data[BOND_W-1:0];
        REG_DRIVE_WEIGHT: drive_r <= signed'(cfg_data[DRIVE_W-1:0]);
        REG_FIELD_WEIGHT: field_r <= signed'(cfg_data[FIELD_W-1:0]);
        REG_HEIGHT_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // site modulo ring size: five restoring compare-subtract steps
  always_comb begin
    logic [SITE_W-1:0]    rem;
    logic [IW+SITE_W-1:0] wide;
    rem = in_site;
    for (int k = 4; k >= 0; k--) begin
      if (32'(rem) >= (SITES << k)) begin
        rem = rem - SITE_W'(SITES << k);
      end
    end
    wide     = (IW+SITE_W)'(rem);
    site_idx = wide[IW-1:0];
  end

  // --------------------------------------------------------------------------
  // ring address: current site plus a small offset, wrapped once
  assign step_s = dir_r ? 3'sd1 : -3'sd1;

  always_comb begin
    offset = 3'sd0;
    case (state_r)
      ST_READ: begin
        case (rd_cnt_r)
          SLOT_NEAR: offset = -step_s;
          SLOT_SITE: offset = 3'sd0;
          SLOT_PAIR: offset = step_s;
          default:   offset = step_s <<< 1;
        endcase
      end
      ST_WR1:  offset = step_s;
      default: offset = 3'sd0;
    endcase
    ring_sum = signed'({2'b00, x_r}) + signed'({{(IW-1){offset[2]}}, offset});
    if (ring_sum < 0) begin
      ring_adj = ring_sum + SITES_S;
    end else if (ring_sum >= SITES_S) begin
      ring_adj = ring_sum - SITES_S;
    end else begin
      ring_adj = ring_sum;
    end
    ring_addr = ring_adj[IW-1:0];
  end

  // --------------------------------------------------------------------------
  // height RAM: clearing pass, then the two writes of an accepted move
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ring_addr;
    ram_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      ST_WR0: begin
        ram_we    = 1'b1;
        ram_wdata = h_r[SLOT_SITE[1:0]] + height_t'(1);
      end
      ST_WR1: begin
        ram_we    = 1'b1;
        ram_wdata = h_r[SLOT_PAIR[1:0]] - height_t'(1);
      end
      default: ram_we = 1'b0;
    endcase
  end

  skms_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (SITES)
  ) u_heights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ring_addr),
    .rdata (ram_rdata)
  );

  assign slot_prev = 2'(rd_cnt_r - 3'd1);

  // --------------------------------------------------------------------------
  // bond change, field step and limit test from the four heights
  function automatic logic [7:0] mag8(input logic signed [7:0] v);
    return (v < 0) ? 8'(-v) : 8'(v);
  endfunction

  always_comb begin
    logic signed [7:0] hn;
    logic signed [7:0] hx;
    logic signed [7:0] hxp;
    logic signed [7:0] hnp;
    logic signed [7:0] lim;
    logic signed [8:0] db_sum;
    logic signed [8:0] m_sum;
    hn  = {{2{h_r[SLOT_NEAR[1:0]][HEIGHT_W-1]}}, h_r[SLOT_NEAR[1:0]]};
    hx  = {{2{h_r[SLOT_SITE[1:0]][HEIGHT_W-1]}}, h_r[SLOT_SITE[1:0]]};
    hxp = {{2{h_r[SLOT_PAIR[1:0]][HEIGHT_W-1]}}, h_r[SLOT_PAIR[1:0]]};
    hnp = {{2{h_r[SLOT_FAR[1:0]][HEIGHT_W-1]}}, h_r[SLOT_FAR[1:0]]};
    lim = signed'({3'b000, limit_r});
    db_sum = signed'({1'b0, mag8(hx + 8'sd1 - hn)})
           + signed'({1'b0, mag8(hx - hxp + 8'sd2)})
           + signed'({1'b0, mag8(hxp - 8'sd1 - hnp)})
           - signed'({1'b0, mag8(hx - hn)})
           - signed'({1'b0, mag8(hx - hxp)})
           - signed'({1'b0, mag8(hxp - hnp)});
    m_sum  = signed'({1'b0, mag8(hx + 8'sd1)}) - signed'({1'b0, mag8(hx)})
           + signed'({1'b0, mag8(hxp - 8'sd1)}) - signed'({1'b0, mag8(hxp)});
    db_nxt  = db_sum[DELTA_W-1:0];
    m_nxt   = m_sum[2:1];   // sum is even, so this halves it exactly
    lim_nxt = (hx + 8'sd1 >= lim) || (hxp - 8'sd1 <= -lim);
  end

  // --------------------------------------------------------------------------
  // Metropolis exponent, Q16
  always_comb begin
    logic [2:0]               db_mag;
    logic [BOND_W+2:0]        bond_term;
    logic signed [EXPO_W-1:0] bond_s;
    logic signed [EXPO_W-1:0] drive_s;
    logic signed [EXPO_W-1:0] field_s;
    db_mag    = (db_r < 0) ? 3'(-db_r) : 3'(db_r);
    bond_term = {3'b000, bond_r} * {20'd0, db_mag};
    bond_s    = signed'(EXPO_W'(bond_term));
    drive_s   = EXPO_W'(drive_r);
    field_s   = EXPO_W'(field_r);
    expo = ((db_r < 0) ? -bond_s : bond_s)
         + (dir_r ? drive_s : -drive_s)
         + ((m_r == 2'sd1) ? field_s : (m_r == -2'sd1) ? -field_s : '0);
    expo_pos = expo > 0;
    expo_big = |expo[EXPO_W-2:FRAC_W+INT_W];
  end

  assign exp_req.go       = (state_r == ST_WEIGH) && !lim_hit_r && expo_pos && !expo_big;
  assign exp_req.int_part = expo[FRAC_W+INT_W-1:FRAC_W];
  assign exp_req.frac     = expo[FRAC_W-1:0];

  skms_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (exp_req),
    .draw  (draw_r),
    .stat  (exp_stat)
  );

  assign energy_nxt = energy_r + {{(ENERGY_W-DELTA_W){db_r[DELTA_W-1]}}, db_r};

  // --------------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      energy_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + IW'(1);
          if (clr_cnt_r == ADDR_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            x_r      <= site_idx;
            dir_r    <= in_direction;
            draw_r   <= in_uniform_draw;
            rd_cnt_r <= '0;
            state_r  <= ST_READ;
          end
        end
        ST_READ: begin
          if (rd_cnt_r != SLOT_NEAR) begin
            h_r[slot_prev] <= height_t'(ram_rdata);
          end
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r == RD_END) begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          db_r      <= db_nxt;
          m_r       <= m_nxt;
          lim_hit_r <= lim_nxt;
          state_r   <= ST_WEIGH;
        end
        ST_WEIGH: begin
          if (lim_hit_r || (expo_pos && expo_big)) begin
            out_valid_r    <= 1'b1;
            out_accepted_r <= 1'b0;
            out_delta_r    <= '0;
            out_energy_r   <= energy_r;
            state_r        <= ST_IDLE;
          end else if (!expo_pos) begin
            state_r <= ST_WR0;
          end else begin
            state_r <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (exp_stat.done) begin
            if (exp_stat.accept) begin
              state_r <= ST_WR0;
            end else begin
              out_valid_r    <= 1'b1;
              out_accepted_r <= 1'b0;
              out_delta_r    <= '0;
              out_energy_r   <= energy_r;
              state_r        <= ST_IDLE;
            end
          end
        end
        ST_WR0: begin
          state_r <= ST_WR1;
        end
        ST_WR1: begin
          energy_r       <= energy_nxt;
          out_valid_r    <= 1'b1;
          out_accepted_r <= 1'b1;
          out_delta_r    <= db_r;
          out_energy_r   <= energy_nxt;
          state_r        <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_energy_change = out_delta_r;
  assign out_bond_energy   = out_energy_r;

  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // one strobe per item, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // a result only follows a cycle of work
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  // a rejected move leaves the energy alone
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_energy_change == '0 && out_bond_energy == energy_r)
    else $error("rejected move reported an energy change");

  // the exp unit only answers while the sequencer waits for it
  a_exp_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    exp_stat.done |-> state_r == ST_EXP)
    else $error("exp unit finished outside its wait state");

  // leaving reset always starts the clearing pass
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> state_r == ST_CLEAR && busy)
    else $error("height RAM not cleared after reset");
`endif

endmodule

`default_nettype wire
